@@ rtl/core/dcfb_pkg.sv @@
// Package for the daisy-chain frame builder and checker.
// Holds the command, result and response codes, the result type and the CRC-8 step.
// No dependencies; used by daisy_chain_frame_builder_checker_unit.
`timescale 1ns / 1ps
`default_nettype none

package dcfb_pkg;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned POS_W       = 7;

    localparam logic [7:0] CRC_POLY       = 8'hB2;
    localparam logic [7:0] OP_WRITE_ALL   = 8'h02;
    localparam logic [2:0] OP_WRITE_DEV   = 3'h2;
    localparam logic [7:0] OP_READ_ALL    = 8'h03;
    localparam logic [2:0] OP_READ_BLOCK  = 3'h6;
    localparam logic [7:0] LEN_WRITE      = 8'h05;
    localparam logic [7:0] LEN_READ_ALL   = 8'h04;
    localparam logic [7:0] LEN_READ_BLOCK = 8'h05;
    localparam logic [7:0] PAD_BYTE       = 8'h00;

    localparam logic [POS_W-1:0] WRITE_PEC_POS  = 7'd5;
    localparam logic [POS_W-1:0] RDALL_PEC_BASE = 7'd4;
    localparam logic [POS_W-1:0] RDBLK_PEC_BASE = 7'd5;
    localparam logic [POS_W-1:0] RDALL_BASE     = 7'd2;
    localparam logic [POS_W-1:0] RDBLK_BASE     = 7'd3;

    localparam logic [2:0] CHAIN_SIZE_ADDR = 3'h0;
    localparam logic [4:0] CHAIN_SIZE_RST  = 5'd1;

    typedef enum logic [2:0] {
        CMD_WRITE_ALL  = 3'd0,
        CMD_WRITE_DEV  = 3'd1,
        CMD_READ_ALL   = 3'd2,
        CMD_READ_BLOCK = 3'd3,
        CMD_RX_BYTE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        EXP_NONE  = 2'd0,
        EXP_WRITE = 2'd1,
        EXP_RDALL = 2'd2,
        EXP_RDBLK = 2'd3
    } expect_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        in_crc;
        logic [15:0] word;
        logic [4:0]  word_index;
        logic        pec_ok;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic result_t tx_entry(input logic [7:0] b, input logic in_crc,
                                         input logic last);
        result_t r;
        r            = '0;
        r.kind       = KIND_TX;
        r.tx_byte    = b;
        r.in_crc     = in_crc;
        r.tx_last    = last;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/daisy_chain_frame_builder_checker_unit.sv @@
// Daisy-chain frame builder and response checker, top level.
// Depends on dcfb_pkg for codes, the result type and the CRC-8 step.
`timescale 1ns / 1ps
`default_nettype none

// A command item (write-all, write-device, read-all, read-block) yields one transmit
// frame on the result port: length byte, command bytes, then the PEC byte with
// tx_last set; it leaves one byte per cycle while out_stall is low, and the frame
// PEC is accumulated as the bytes leave. Each command also arms the expected
// response layout. A received-byte item yields at most one result (a data word, or
// the status at the PEC byte). Words leave before the status, so a consumer must drop
// the words of a response whose status has pec_ok low. A new item is taken when the
// result port is empty or in the same cycle the last result of the previous one is
// taken; the six-entry result shift line and its single output port set the rate.
// chain_size lives at byte address 0 of the APB port and resets to 1.
module daisy_chain_frame_builder_checker_unit
    import dcfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [4:0]  device_addr,
    input  wire logic [7:0]  reg_addr,
    input  wire logic [15:0] write_data,
    input  wire logic [4:0]  blk_count,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  kind,
    output logic      [7:0]  tx_byte,
    output logic             tx_last,
    output logic      [15:0] word,
    output logic      [4:0]  word_index,
    output logic             pec_ok
);

    logic [4:0]       chain_size_reg;
    logic             cfg_write;

    result_t          buf_reg  [MAX_RESULTS];
    result_t          buf_next [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       tx_crc_reg, tx_crc_next;

    expect_t          expect_reg, expect_next;
    logic [POS_W-1:0] rx_pos_reg, rx_pos_next;
    logic [7:0]       rx_crc_reg, rx_crc_next;
    logic [7:0]       held_reg, held_next;
    logic [4:0]       armed_reg, armed_next;

    logic             accept;
    logic             take;
    cmd_t             cmd_sel;
    logic [4:0]       nwords;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] pec_pos;
    logic [POS_W-1:0] rel;
    result_t          res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CHAIN_SIZE_ADDR[2]);
    assign prdata    = (paddr[2] == CHAIN_SIZE_ADDR[2]) ? {27'd0, chain_size_reg} : 32'd0;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && take));
    assign accept    = in_valid && !in_stall;
    assign cmd_sel   = cmd_t'(cmd);

    assign kind       = buf_reg[0].kind;
    assign tx_byte    = buf_reg[0].tx_last ? tx_crc_reg : buf_reg[0].tx_byte;
    assign tx_last    = buf_reg[0].tx_last;
    assign word       = buf_reg[0].word;
    assign word_index = buf_reg[0].word_index;
    assign pec_ok     = buf_reg[0].pec_ok;

    always_comb
    begin
        unique case (expect_reg)
            EXP_RDALL:
            begin
                nwords  = chain_size_reg;
                base    = RDALL_BASE;
                pec_pos = RDALL_PEC_BASE + {1'b0, chain_size_reg, 1'b0};
            end
            EXP_RDBLK:
            begin
                nwords  = armed_reg;
                base    = RDBLK_BASE;
                pec_pos = RDBLK_PEC_BASE + {1'b0, armed_reg, 1'b0};
            end
            default:
            begin
                nwords  = '0;
                base    = '0;
                pec_pos = WRITE_PEC_POS;
            end
        endcase
        rel = rx_pos_reg - base;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next    = cnt_reg;
        tx_crc_next = tx_crc_reg;
        expect_next = expect_reg;
        rx_pos_next = rx_pos_reg;
        rx_crc_next = rx_crc_reg;
        held_next   = held_reg;
        armed_next  = armed_reg;
        res         = '0;

        if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (buf_reg[0].in_crc)
            begin
                tx_crc_next = crc8_byte(tx_crc_reg, buf_reg[0].tx_byte);
            end
        end

        if (accept)
        begin
            unique case (cmd_sel) inside
                CMD_WRITE_ALL, CMD_WRITE_DEV:
                begin
                    buf_next[0] = tx_entry(LEN_WRITE, 1'b0, 1'b0);
                    buf_next[1] = tx_entry((cmd_sel == CMD_WRITE_ALL) ? OP_WRITE_ALL
                                           : {device_addr, OP_WRITE_DEV}, 1'b1, 1'b0);
                    buf_next[2] = tx_entry(reg_addr, 1'b1, 1'b0);
                    buf_next[3] = tx_entry(write_data[7:0], 1'b1, 1'b0);
                    buf_next[4] = tx_entry(write_data[15:8], 1'b1, 1'b0);
                    buf_next[5] = tx_entry(PAD_BYTE, 1'b0, 1'b1);
                    cnt_next    = CNT_W'(6);
                    tx_crc_next = '0;
                    expect_next = EXP_WRITE;
                    rx_pos_next = '0;
                    rx_crc_next = '0;
                    held_next   = '0;
                end
                CMD_READ_ALL:
                begin
                    buf_next[0] = tx_entry(LEN_READ_ALL + {2'b0, chain_size_reg, 1'b0},
                                           1'b0, 1'b0);
                    buf_next[1] = tx_entry(OP_READ_ALL, 1'b1, 1'b0);
                    buf_next[2] = tx_entry(reg_addr, 1'b1, 1'b0);
                    buf_next[3] = tx_entry(PAD_BYTE, 1'b1, 1'b0);
                    buf_next[4] = tx_entry(PAD_BYTE, 1'b0, 1'b1);
                    cnt_next    = CNT_W'(5);
                    tx_crc_next = '0;
                    expect_next = EXP_RDALL;
                    rx_pos_next = '0;
                    rx_crc_next = '0;
                    held_next   = '0;
                end
                CMD_READ_BLOCK:
                begin
                    buf_next[0] = tx_entry(LEN_READ_BLOCK + {2'b0, blk_count, 1'b0},
                                           1'b0, 1'b0);
                    buf_next[1] = tx_entry({blk_count, OP_READ_BLOCK}, 1'b1, 1'b0);
                    buf_next[2] = tx_entry({3'b0, device_addr}, 1'b1, 1'b0);
                    buf_next[3] = tx_entry(reg_addr, 1'b1, 1'b0);
                    buf_next[4] = tx_entry(PAD_BYTE, 1'b1, 1'b0);
                    buf_next[5] = tx_entry(PAD_BYTE, 1'b0, 1'b1);
                    cnt_next    = CNT_W'(6);
                    tx_crc_next = '0;
                    armed_next  = blk_count;
                    expect_next = EXP_RDBLK;
                    rx_pos_next = '0;
                    rx_crc_next = '0;
                    held_next   = '0;
                end
                CMD_RX_BYTE:
                begin
                    if (expect_reg != EXP_NONE)
                    begin
                        if (rx_pos_reg >= pec_pos)
                        begin
                            res.kind    = KIND_STATUS;
                            res.pec_ok  = (rx_byte == rx_crc_reg);
                            buf_next[0] = res;
                            cnt_next    = CNT_W'(1);
                            expect_next = EXP_NONE;
                            rx_pos_next = '0;
                            rx_crc_next = '0;
                            held_next   = '0;
                        end
                        else
                        begin
                            rx_crc_next = crc8_byte(rx_crc_reg, rx_byte);
                            rx_pos_next = rx_pos_reg + POS_W'(1);
                            if ((nwords != '0) && (rx_pos_reg >= base)
                                && (rel[POS_W-1:1] < {1'b0, nwords}))
                            begin
                                if (!rel[0])
                                begin
                                    held_next = rx_byte;
                                end
                                else
                                begin
                                    res.kind       = KIND_WORD;
                                    res.word       = {rx_byte, held_reg};
                                    res.word_index = rel[5:1];
                                    buf_next[0]    = res;
                                    cnt_next       = CNT_W'(1);
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_size_reg <= CHAIN_SIZE_RST;
            cnt_reg        <= '0;
            tx_crc_reg     <= '0;
            expect_reg     <= EXP_NONE;
            rx_pos_reg     <= '0;
            rx_crc_reg     <= '0;
            held_reg       <= '0;
            armed_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                chain_size_reg <= pwdata[4:0];
            end
            cnt_reg    <= cnt_next;
            tx_crc_reg <= tx_crc_next;
            expect_reg <= expect_next;
            rx_pos_reg <= rx_pos_next;
            rx_crc_reg <= rx_crc_next;
            held_reg   <= held_next;
            armed_reg  <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count above frame size");

    a_rdall_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_sel == CMD_READ_ALL)) |=> (cnt_reg == CNT_W'(5)) && buf_reg[4].tx_last)
        else $error("read-all frame not loaded");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (expect_reg == EXP_NONE) |-> ((rx_pos_reg == '0) && (rx_crc_reg == '0)))
        else $error("response state not cleared while idle");

    a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && buf_reg[0].tx_last) |-> (buf_reg[0].kind == KIND_TX))
        else $error("tx_last on non-transmit result");

endmodule

`default_nettype wire

@@ sim/dcfb_link_checker.sv @@
// Result checker for daisy_chain_frame_builder_checker_unit.
// Watches the APB port and both item channels, forecasts the frames, words and
// status items, and compares them. Depends on dcfb_pkg for codes and constants.
`timescale 1ns / 1ps

module dcfb_link_checker
    import dcfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [4:0]  device_addr,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic [4:0]  blk_count,
    input  logic [7:0]  rx_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  tx_byte,
    input  logic        tx_last,
    input  logic [15:0] word,
    input  logic [4:0]  word_index,
    input  logic        pec_ok,

    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] word;
        logic [4:0]  word_index;
        logic        pec_ok;
    } link_result_t;

    link_result_t due_results[$];

    logic [4:0] chain      = CHAIN_SIZE_RST;
    expect_t    mode       = EXP_NONE;
    logic [6:0] rx_pos     = '0;
    logic [7:0] rx_crc     = '0;
    logic [7:0] low_hold   = '0;
    logic [4:0] blk_armed  = '0;

    initial mismatches = 0;

    // reflected CRC-8, one data bit per step
    function automatic logic [7:0] pec8(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        int         i;
        r = acc;
        for (i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic arm(input expect_t m);
        mode     = m;
        rx_pos   = '0;
        rx_crc   = '0;
        low_hold = '0;
    endtask

    task automatic queue_tx(input logic [7:0] b, input logic last);
        link_result_t r;
        r         = '0;
        r.kind    = KIND_TX;
        r.tx_byte = b;
        r.tx_last = last;
        due_results.push_back(r);
    endtask

    // body byte 0 sits in bits 7:0
    task automatic queue_frame(input logic [7:0] len, input logic [31:0] body, input int n);
        logic [7:0] acc;
        int         i;
        acc = '0;
        queue_tx(len, 1'b0);
        for (i = 0; i < n; i++) begin
            acc = pec8(acc, body[8*i +: 8]);
            queue_tx(body[8*i +: 8], 1'b0);
        end
        queue_tx(acc, 1'b1);
    endtask

    task automatic take_rx(input logic [7:0] rxb);
        link_result_t r;
        int           words;
        int           base;
        int           pec_at;
        int           rel;
        words  = 0;
        base   = 0;
        pec_at = WRITE_PEC_POS;
        if (mode == EXP_RDALL) begin
            words  = chain;
            base   = RDALL_BASE;
            pec_at = RDALL_PEC_BASE + 2 * chain;
        end else if (mode == EXP_RDBLK) begin
            words  = blk_armed;
            base   = RDBLK_BASE;
            pec_at = RDBLK_PEC_BASE + 2 * blk_armed;
        end
        if (mode == EXP_NONE) begin
        end else if (int'(rx_pos) >= pec_at) begin
            r        = '0;
            r.kind   = KIND_STATUS;
            r.pec_ok = (rxb == rx_crc);
            due_results.push_back(r);
            arm(EXP_NONE);
        end else begin
            rx_crc = pec8(rx_crc, rxb);
            rel    = int'(rx_pos) - base;
            if (words != 0 && rel >= 0 && (rel / 2) < words) begin
                if (rel % 2 == 0) begin
                    low_hold = rxb;
                end else begin
                    r            = '0;
                    r.kind       = KIND_WORD;
                    r.word       = {rxb, low_hold};
                    r.word_index = 5'(rel / 2);
                    due_results.push_back(r);
                end
            end
            rx_pos = rx_pos + 7'd1;
        end
    endtask

    task automatic step_link(input logic [2:0] c, input logic [4:0] dev, input logic [7:0] ra,
                             input logic [15:0] wd, input logic [4:0] blk,
                             input logic [7:0] rxb);
        logic [7:0] first;
        case (c)
            CMD_WRITE_ALL, CMD_WRITE_DEV: begin
                first = (c == CMD_WRITE_ALL) ? OP_WRITE_ALL : {dev, OP_WRITE_DEV};
                arm(EXP_WRITE);
                queue_frame(LEN_WRITE, {wd[15:8], wd[7:0], ra, first}, 4);
            end
            CMD_READ_ALL: begin
                arm(EXP_RDALL);
                queue_frame(LEN_READ_ALL + {2'b00, chain, 1'b0},
                            {8'h00, PAD_BYTE, ra, OP_READ_ALL}, 3);
            end
            CMD_READ_BLOCK: begin
                blk_armed = blk;
                arm(EXP_RDBLK);
                queue_frame(LEN_READ_BLOCK + {2'b00, blk, 1'b0},
                            {PAD_BYTE, ra, {3'b000, dev}, {blk, OP_READ_BLOCK}}, 4);
            end
            CMD_RX_BYTE: take_rx(rxb);
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        link_result_t want;
        if (!rst_n) begin
            due_results.delete();
            chain     = CHAIN_SIZE_RST;
            blk_armed = '0;
            arm(EXP_NONE);
            outstanding <= 0;
        end else begin
            // compare before queueing the item taken at this same edge
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $error("unexpected result: kind 0x%0h", kind);
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("tx_byte", want.tx_byte, tx_byte);
                    check_field("tx_last", want.tx_last, tx_last);
                    check_field("word", want.word, word);
                    check_field("word_index", want.word_index, word_index);
                    check_field("pec_ok", want.pec_ok, pec_ok);
                end
            end
            if (in_valid && !in_stall)
                step_link(cmd, device_addr, reg_addr, write_data, blk_count, rx_byte);
            if (psel && penable && pwrite && pready && paddr == CHAIN_SIZE_ADDR)
                chain = pwdata[4:0];
            outstanding <= due_results.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Stimulus and verdict for daisy_chain_frame_builder_checker_unit.
// Drives commands, received response frames and chain_size writes; results are
// judged by dcfb_link_checker. Depends on dcfb_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;
    import dcfb_pkg::*;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
    localparam int         PHASE_ITEMS      = 80;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [4:0]  device_addr;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic [4:0]  blk_count;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] word;
    logic [4:0]  word_index;
    logic        pec_ok;
    int          mismatches;
    int          outstanding;

    logic        calm = 1'b0;
    int          chain_now = CHAIN_SIZE_RST;
    int          counted = 0;

    daisy_chain_frame_builder_checker_unit dut (.*);
    dcfb_link_checker link_check (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("daisy_chain_frame_builder_checker_unit test failed");
        $finish;
    end

    // result side: draw a stall for every item
    initial begin
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 12);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic push_item(input logic [2:0] c, input logic [4:0] dev, input logic [7:0] ra,
                             input logic [15:0] wd, input logic [4:0] blk,
                             input logic [7:0] rxb);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        device_addr <= dev;
        reg_addr    <= ra;
        write_data  <= wd;
        blk_count   <= blk;
        rx_byte     <= rxb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_command(input logic [2:0] c, input logic [4:0] blk, output int pec_at);
        push_item(c, 5'($urandom), 8'($urandom), 16'($urandom), blk, 8'($urandom));
        counted++;
        if (c == CMD_READ_ALL)
            pec_at = RDALL_PEC_BASE + 2 * chain_now;
        else if (c == CMD_READ_BLOCK)
            pec_at = RDBLK_PEC_BASE + 2 * blk;
        else
            pec_at = WRITE_PEC_POS;
    endtask

    // stop_at above pec_at sends the whole frame including the PEC
    task automatic send_response(input int pec_at, input bit spoil, input int stop_at);
        logic [7:0] acc;
        logic [7:0] b;
        int         k;
        acc = '0;
        for (k = 0; k < pec_at && k < stop_at; k++) begin
            b   = 8'($urandom);
            acc = crc8_byte(acc, b);
            push_item(CMD_RX_BYTE, 5'($urandom), 8'($urandom), 16'($urandom), 5'($urandom), b);
            counted++;
        end
        if (stop_at > pec_at) begin
            if (spoil)
                acc = acc ^ 8'($urandom_range(1, 255));
            push_item(CMD_RX_BYTE, 5'($urandom), 8'($urandom), 16'($urandom), 5'($urandom),
                      acc);
            counted++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int target);
        logic [2:0] c;
        logic [4:0] blk;
        int         pick;
        int         pec_at;
        counted = 0;
        while (counted < target) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: stray received bytes and unused codes
                repeat ($urandom_range(1, 3))
                    push_item(CMD_RX_BYTE, 5'($urandom), 8'($urandom), 16'($urandom),
                              5'($urandom), 8'($urandom));
                push_item(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), 5'($urandom),
                          8'($urandom), 16'($urandom), 5'($urandom), 8'($urandom));
            end else begin
                c   = 3'($urandom_range(CMD_WRITE_ALL, CMD_READ_BLOCK));
                blk = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 4));
                send_command(c, blk, pec_at);
                if (pick < 20)
                    send_response(pec_at, 1'b0, $urandom_range(0, pec_at));
                else
                    send_response(pec_at, ($urandom_range(0, 5) == 0), pec_at + 1);
            end
        end
    endtask

    initial begin
        int chains[5];
        int p;
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        cmd         <= CMD_WRITE_ALL;
        device_addr <= '0;
        reg_addr    <= '0;
        write_data  <= '0;
        blk_count   <= '0;
        rx_byte     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= CHAIN_SIZE_ADDR;
        pwdata      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, write-device reply, ignored bytes and codes
        push_item(CMD_WRITE_ALL, 5'd0, 8'hFF, 16'hFFFF, 5'd0, 8'h00);
        push_item(CMD_WRITE_DEV, 5'd31, 8'h00, 16'h0000, 5'd31, 8'hFF);
        send_response(WRITE_PEC_POS, 1'b0, WRITE_PEC_POS + 1);
        push_item(CMD_RX_BYTE, 5'd0, 8'h00, 16'h0000, 5'd0, 8'hA5);
        push_item(CMD_UNUSED_FIRST, 5'd31, 8'hFF, 16'hFFFF, 5'd31, 8'hFF);
        push_item(CMD_UNUSED_MID, 5'd0, 8'h00, 16'h0000, 5'd0, 8'h00);
        push_item(CMD_UNUSED_LAST, 5'd31, 8'hFF, 16'hFFFF, 5'd31, 8'hFF);
        // empty block read answered with a broken PEC
        push_item(CMD_READ_BLOCK, 5'd31, 8'hFF, 16'h0000, 5'd0, 8'h00);
        send_response(RDBLK_PEC_BASE, 1'b1, RDBLK_PEC_BASE + 1);
        // shrink the chain while a read-all reply is armed
        push_item(CMD_READ_ALL, 5'd0, 8'h5A, 16'h0000, 5'd0, 8'h00);
        settle();
        apb_write(CHAIN_SIZE_ADDR, 32'd0);
        chain_now = 0;
        send_response(RDALL_PEC_BASE, 1'b0, RDALL_PEC_BASE + 1);

        chains = '{31, 1, $urandom_range(2, 30), 0, $urandom_range(0, 31)};
        for (p = 0; p < 5; p++) begin
            settle();
            apb_write(CHAIN_SIZE_ADDR, 32'(chains[p]));
            chain_now = chains[p];
            run_random(PHASE_ITEMS);
        end
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("daisy_chain_frame_builder_checker_unit test passed");
        else
            $display("daisy_chain_frame_builder_checker_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dcfb_pkg.sv
rtl/core/daisy_chain_frame_builder_checker_unit.sv
sim/dcfb_link_checker.sv
sim/testbench.sv
